>>> src/cqm_pkg.sv
// ----------------------------------------------------------------------------
// cqm_pkg
// Shared types and constants for the comment and quote masker.
// ----------------------------------------------------------------------------
`default_nettype none

package cqm_pkg;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    MODE_CODE  = 3'd0,
    MODE_SQ    = 3'd1,
    MODE_DQ    = 3'd2,
    MODE_HASH  = 3'd3,
    MODE_SS    = 3'd4,
    MODE_BLOCK = 3'd5
  } mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_ch;
    logic       out_last;
    logic [2:0] out_mode;
  } out_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] prev_ch;
    logic [7:0] held_ch;
    logic       held_vld;
  } cqm_state_t;

  typedef struct packed {
    logic first_vld;
    out_t first;
    logic second_vld;
    out_t second;
  } cqm_res_t;

endpackage

`default_nettype wire

>>> src/cqm_step.sv
// ----------------------------------------------------------------------------
// cqm_step
// Next-state and result logic for one input character.
// ----------------------------------------------------------------------------
`default_nettype none

module cqm_step (
  input  wire logic [7:0]          ch,
  input  wire logic                line_end,
  input  wire cqm_pkg::cqm_state_t cur,
  output cqm_pkg::cqm_state_t      nxt,
  output cqm_pkg::cqm_res_t        res
);
  import cqm_pkg::*;

  mode_t      s;
  logic [7:0] p;
  logic [7:0] oc;
  logic [7:0] held;
  logic       not_esc;

  always_comb begin
    s       = cur.mode;
    p       = cur.prev_ch;
    oc      = ch;
    held    = cur.held_ch;
    not_esc = (cur.prev_ch != CH_BSLASH);

    if (ch == CH_SQUOTE && not_esc && cur.mode == MODE_CODE) begin
      s = MODE_SQ;
    end else begin
      if (ch == CH_SQUOTE && not_esc && cur.mode == MODE_SQ) begin
        s = MODE_CODE;
      end
      if (ch == CH_DQUOTE && not_esc && (s == MODE_CODE || s == MODE_DQ)) begin
        s = (s == MODE_DQ) ? MODE_CODE : MODE_DQ;
      end else if (ch == CH_HASH && s == MODE_CODE) begin
        s = MODE_HASH;
      end else if (ch == CH_SLASH && cur.prev_ch == CH_SLASH && s == MODE_CODE) begin
        s = MODE_SS;
      end else if (ch == CH_STAR && cur.prev_ch == CH_SLASH && s == MODE_CODE) begin
        s = MODE_BLOCK;
      end else if (ch == CH_SLASH && cur.prev_ch == CH_STAR && s == MODE_BLOCK) begin
        s    = MODE_CODE;
        held = CH_STAR;
      end else if (ch == CH_NL) begin
        if (s == MODE_HASH || s == MODE_SS) begin
          s = MODE_CODE;
        end
      end else begin
        p = ch;
        if (s != MODE_CODE) begin
          oc = CH_UNDER;
        end
      end
    end

    res.first_vld       = cur.held_vld;
    res.first.out_ch    = held;
    res.first.out_last  = 1'b0;
    res.first.out_mode  = s;
    res.second_vld      = line_end;
    res.second.out_ch   = oc;
    res.second.out_last = 1'b1;
    res.second.out_mode = s;

    nxt.mode     = s;
    nxt.prev_ch  = line_end ? CH_SPACE : p;
    nxt.held_ch  = oc;
    nxt.held_vld = !line_end;
  end

endmodule

`default_nettype wire

>>> src/comment_and_quote_masker.sv
// ----------------------------------------------------------------------------
// comment_and_quote_masker
// Masks the insides of quotes and comments in a character stream.
// ----------------------------------------------------------------------------
// The block takes one character per cycle while in_stall is low and updates
// its mode in the same cycle, so the next request can follow at once. Each
// character leaves one character later, except the last character of a line,
// which leaves in the same step right after the held one, so a line-end
// request can produce two results. Results wait in a four-entry queue that
// sends one per cycle while out_stall is low; the input stalls while the
// queue holds more than two entries. Accepted results are registered in it.
`default_nettype none

module comment_and_quote_masker (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire cqm_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output cqm_pkg::out_t      out_data
);
  import cqm_pkg::*;

  cqm_state_t st_r;
  cqm_state_t st_nxt;
  cqm_res_t   res;

  out_t             q_r [QDEPTH];
  logic [QAW-1:0]   head_r;
  logic [QAW-1:0]   tail_r;
  logic [QCW-1:0]   cnt_r;
  logic [QAW-1:0]   tail2;
  logic             acc;
  logic             pop;
  logic [QCW-1:0]   n_push;

  cqm_step u_step (
    .ch       (in_data.ch),
    .line_end (in_data.line_end),
    .cur      (st_r),
    .nxt      (st_nxt),
    .res      (res)
  );

  assign in_stall  = (cnt_r > QCW'(QDEPTH - 2));
  assign acc       = in_valid && !in_stall;
  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[head_r];
  assign pop       = out_valid && !out_stall;
  assign n_push    = acc ? (QCW'(res.first_vld) + QCW'(res.second_vld)) : '0;
  assign tail2     = res.first_vld ? (tail_r + 1'b1) : tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode     <= MODE_CODE;
      st_r.prev_ch  <= CH_SPACE;
      st_r.held_vld <= 1'b0;
      head_r        <= '0;
      tail_r        <= '0;
      cnt_r         <= '0;
    end else begin
      if (acc) begin
        st_r.mode     <= st_nxt.mode;
        st_r.prev_ch  <= st_nxt.prev_ch;
        st_r.held_ch  <= st_nxt.held_ch;
        st_r.held_vld <= st_nxt.held_vld;
      end
      if (pop) begin
        head_r <= head_r + 1'b1;
      end
      tail_r <= tail_r + QAW'(n_push);
      cnt_r  <= cnt_r + n_push - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (res.first_vld) begin
        q_r[tail_r] <= res.first;
      end
      if (res.second_vld) begin
        q_r[tail2] <= res.second;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/cqm_checker.sv
// ----------------------------------------------------------------------------
// cqm_checker
// Port-level assertions for the comment and quote masker.
// ----------------------------------------------------------------------------
`default_nettype none

module cqm_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire cqm_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire cqm_pkg::out_t out_data
);
  import cqm_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("Stalled request changed.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed.");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_mode <= 3'(MODE_BLOCK))
    else $error("Result mode out of range.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result present right after reset.");

  a_nl_ends_line_comment: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_last && out_data.out_ch == CH_NL |->
      out_data.out_mode != 3'(MODE_HASH) && out_data.out_mode != 3'(MODE_SS))
    else $error("Newline at line end left a line comment open.");

endmodule

bind comment_and_quote_masker cqm_checker u_cqm_checker (.*);

`default_nettype wire
